### hdl/bpc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and limits for the barometric compensation block.
package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int DT_W      = 25;
    localparam int MB_W      = 18;
    localparam int PROD_W    = DT_W + MB_W;
    localparam int OFF_W     = 37;
    localparam int SENS_W    = 35;
    localparam int SENS_LO_W = 17;
    localparam int FULL_W    = 60;
    localparam int DIFF_W    = 40;

    localparam int TEMP_W    = 18;
    localparam int PRES_W    = 23;
    localparam int TSUM_W    = 21;
    localparam int PWIDE_W   = 25;

    localparam int C5_SHIFT   = 8;
    localparam int C2_SHIFT   = 16;
    localparam int C1_SHIFT   = 15;
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int PROD_SHIFT = 21;
    localparam int PRES_SHIFT = 15;

    localparam logic signed [TSUM_W-1:0] TEMP_BASE = 21'sd2000;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};
    localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
    localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] IDX_PRESSURE_SENSITIVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_PRESSURE_OFFSET       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SENSITIVITY_TEMP_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_OFFSET_TEMP_COEF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_REFERENCE_TEMPERATURE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_TEMPERATURE_COEF      = 3'd5;

endpackage

### hdl/bpc_sample_if.sv
`timescale 1ns / 1ps
// Raw reading channel: valid/ready handshake with pressure and temperature payload.
interface bpc_sample_if;
    logic                           valid;
    logic                           ready;
    logic [bpc_pkg::RAW_W-1:0]      pressure_raw;
    logic [bpc_pkg::RAW_W-1:0]      temperature_raw;

    modport source (output valid, output pressure_raw, output temperature_raw, input ready);
    modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

### hdl/bpc_result_if.sv
`timescale 1ns / 1ps
// Compensated result channel: valid/ready handshake with temperature and pressure payload.
interface bpc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpc_pkg::TEMP_W-1:0]  temperature_centi;
    logic signed [bpc_pkg::PRES_W-1:0]  pressure_comp;

    modport source (output valid, output temperature_centi, output pressure_comp, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_comp, output ready);
endinterface

### hdl/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// Top level: six-stage pipeline for first-order barometric sensor compensation.
//
// Takes one raw pressure/temperature pair per clock while the result is not stalled and
// returns the compensated temperature (hundredths of a degree, saturated to 18 bits)
// and pressure, one result per cycle sustained. A sample passes the registers of the
// multiplier chain in order: dT, then the three coefficient products, then OFF/SENS,
// then the pressure product taken as two 25x18 partial products, then their sum, then
// the final subtract, shift and clamp into the output register. Each stage holds while
// the stage after it is full and stalled, and empty stages fill, so a stalled result
// does not block new samples until the pipeline is full. Calibration words are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while no sample is
// in flight (the block does not enforce this), and indexes above five are ignored.
module baro_pressure_temp_compensation
(
    input  logic                                clk,
    input  logic                                rst_n,
    bpc_sample_if.sink                          sample,
    bpc_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]          cfg_wdata
);

    logic [bpc_pkg::COEF_W-1:0] c1_reg;
    logic [bpc_pkg::COEF_W-1:0] c2_reg;
    logic [bpc_pkg::COEF_W-1:0] c3_reg;
    logic [bpc_pkg::COEF_W-1:0] c4_reg;
    logic [bpc_pkg::COEF_W-1:0] c5_reg;
    logic [bpc_pkg::COEF_W-1:0] c6_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    logic signed [bpc_pkg::DT_W-1:0]    dt_reg;
    logic signed [bpc_pkg::DT_W-1:0]    dt_next;
    logic signed [bpc_pkg::DT_W-1:0]    d1_s1_reg;
    logic signed [bpc_pkg::DT_W-1:0]    d1_s2_reg;
    logic signed [bpc_pkg::DT_W-1:0]    d1_s3_reg;

    logic signed [bpc_pkg::PROD_W-1:0]  p3_prod, p4_prod, p6_prod;
    logic signed [bpc_pkg::PROD_W-1:0]  lo_prod, hi_prod;

    logic signed [bpc_pkg::TSUM_W-1:0]  temp_sum;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp_next;
    logic signed [bpc_pkg::OFF_W-1:0]   off_next;
    logic signed [bpc_pkg::SENS_W-1:0]  sens_next;

    logic signed [bpc_pkg::TEMP_W-1:0]  temp_s3_reg, temp_s4_reg, temp_s5_reg, temp_out_reg;
    logic signed [bpc_pkg::OFF_W-1:0]   off_s3_reg, off_s4_reg, off_s5_reg;
    logic signed [bpc_pkg::SENS_W-1:0]  sens_s3_reg;

    logic signed [bpc_pkg::FULL_W-1:0]  full_next;
    logic signed [bpc_pkg::FULL_W-1:0]  full_reg;
    logic signed [bpc_pkg::DIFF_W-1:0]  diff;
    logic signed [bpc_pkg::PWIDE_W-1:0] pres_wide;
    logic signed [bpc_pkg::PRES_W-1:0]  pres_next;
    logic signed [bpc_pkg::PRES_W-1:0]  pres_out_reg;

    // calibration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpc_pkg::IDX_PRESSURE_SENSITIVITY:  c1_reg <= cfg_wdata;
                bpc_pkg::IDX_PRESSURE_OFFSET:       c2_reg <= cfg_wdata;
                bpc_pkg::IDX_SENSITIVITY_TEMP_COEF: c3_reg <= cfg_wdata;
                bpc_pkg::IDX_OFFSET_TEMP_COEF:      c4_reg <= cfg_wdata;
                bpc_pkg::IDX_REFERENCE_TEMPERATURE: c5_reg <= cfg_wdata;
                bpc_pkg::IDX_TEMPERATURE_COEF:      c6_reg <= cfg_wdata;
                default:                            ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    assign en6 = !v6_reg || result.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign sample.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= sample.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1: dT
    assign dt_next = $signed({1'b0, sample.temperature_raw})
                   - $signed({1'b0, c5_reg, {bpc_pkg::C5_SHIFT{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= $signed({1'b0, sample.pressure_raw});
        end
    end

    // stage 2: coefficient products
    bpc_mul u_mul_c6
    (
        .clk  (clk),
        .en   (en2),
        .a    (dt_reg),
        .b    ($signed({2'b00, c6_reg})),
        .prod (p6_prod)
    );

    bpc_mul u_mul_c4
    (
        .clk  (clk),
        .en   (en2),
        .a    (dt_reg),
        .b    ($signed({2'b00, c4_reg})),
        .prod (p4_prod)
    );

    bpc_mul u_mul_c3
    (
        .clk  (clk),
        .en   (en2),
        .a    (dt_reg),
        .b    ($signed({2'b00, c3_reg})),
        .prod (p3_prod)
    );

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            d1_s2_reg <= d1_s1_reg;
        end
    end

    // stage 3: TEMP, OFF, SENS
    always_comb
    begin
        temp_sum = $signed({p6_prod[bpc_pkg::PROD_W-1],
                            p6_prod[bpc_pkg::PROD_W-1:bpc_pkg::TEMP_SHIFT]})
                 + bpc_pkg::TEMP_BASE;
        if (temp_sum > bpc_pkg::TEMP_MAX)
        begin
            temp_next = bpc_pkg::TEMP_MAX;
        end
        else if (temp_sum < bpc_pkg::TEMP_MIN)
        begin
            temp_next = bpc_pkg::TEMP_MIN;
        end
        else
        begin
            temp_next = temp_sum[bpc_pkg::TEMP_W-1:0];
        end

        off_next = $signed({p4_prod[bpc_pkg::PROD_W-1],
                            p4_prod[bpc_pkg::PROD_W-1:bpc_pkg::OFF_SHIFT]})
                 + $signed({5'b0, c2_reg, {bpc_pkg::C2_SHIFT{1'b0}}});

        sens_next = $signed(p3_prod[bpc_pkg::PROD_W-1:bpc_pkg::SENS_SHIFT])
                  + $signed({4'b0, c1_reg, {bpc_pkg::C1_SHIFT{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            temp_s3_reg <= temp_next;
            off_s3_reg  <= off_next;
            sens_s3_reg <= sens_next;
            d1_s3_reg   <= d1_s2_reg;
        end
    end

    // stage 4: D1 * SENS as two partial products
    bpc_mul u_mul_lo
    (
        .clk  (clk),
        .en   (en4),
        .a    (d1_s3_reg),
        .b    ($signed({1'b0, sens_s3_reg[bpc_pkg::SENS_LO_W-1:0]})),
        .prod (lo_prod)
    );

    bpc_mul u_mul_hi
    (
        .clk  (clk),
        .en   (en4),
        .a    (d1_s3_reg),
        .b    ($signed(sens_s3_reg[bpc_pkg::SENS_W-1:bpc_pkg::SENS_LO_W])),
        .prod (hi_prod)
    );

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
        end
    end

    // stage 5: combine partial products
    assign full_next = $signed({hi_prod, {bpc_pkg::SENS_LO_W{1'b0}}})
                     + $signed({{(bpc_pkg::FULL_W-bpc_pkg::PROD_W){lo_prod[bpc_pkg::PROD_W-1]}},
                                lo_prod});

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            full_reg    <= full_next;
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
        end
    end

    // stage 6: subtract OFF, shift, clamp
    always_comb
    begin
        diff = $signed({full_reg[bpc_pkg::FULL_W-1],
                        full_reg[bpc_pkg::FULL_W-1:bpc_pkg::PROD_SHIFT]})
             - $signed({{(bpc_pkg::DIFF_W-bpc_pkg::OFF_W){off_s5_reg[bpc_pkg::OFF_W-1]}},
                        off_s5_reg});
        pres_wide = $signed(diff[bpc_pkg::DIFF_W-1:bpc_pkg::PRES_SHIFT]);
        if (pres_wide > bpc_pkg::PRES_MAX)
        begin
            pres_next = bpc_pkg::PRES_MAX;
        end
        else if (pres_wide < bpc_pkg::PRES_MIN)
        begin
            pres_next = bpc_pkg::PRES_MIN;
        end
        else
        begin
            pres_next = pres_wide[bpc_pkg::PRES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            temp_out_reg <= temp_s5_reg;
            pres_out_reg <= pres_next;
        end
    end

    assign result.valid             = v6_reg;
    assign result.temperature_centi = temp_out_reg;
    assign result.pressure_comp     = pres_out_reg;

    a_empty_out_takes_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> sample.ready)
        else $error("pipeline refuses a sample with an empty output");

    a_stall_only_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("sample stalled without output back-pressure");

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> v1_reg)
        else $error("accepted sample lost at first stage");

    a_full_chain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && result.ready) |=> result.valid)
        else $error("result lost between last two stages");

endmodule

### hdl/bpc_mul.sv
`timescale 1ns / 1ps
// Registered 25x18 signed multiplier stage with load enable.
module bpc_mul
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [bpc_pkg::DT_W-1:0]     a,
    input  logic signed [bpc_pkg::MB_W-1:0]     b,
    output logic signed [bpc_pkg::PROD_W-1:0]   prod
);

    logic signed [bpc_pkg::PROD_W-1:0] prod_reg;
    logic signed [bpc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
